[rtl/mersenne_twister_prng_macros.svh]
// Assertion macros for the MT19937 generator.
// Used by the top level; relies on clk and rst_n in the including scope.
`ifndef MERSENNE_TWISTER_PRNG_MACROS_SVH
`define MERSENNE_TWISTER_PRNG_MACROS_SVH
`ifndef SYNTHESIS
`define MTP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("mtp assertion failed");
`define MTP_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("mtp assertion failed");
`else
`define MTP_ASSERT(lbl, prop)
`define MTP_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

[rtl/mtp_pkg.sv]
// Package for the MT19937 generator: constants, command/status types, tempering.
// No dependencies.
package mtp_pkg;
    localparam int unsigned STATE_WORDS  = 624;
    localparam int unsigned TWIST_OFFSET = 397;
    localparam int unsigned IDX_W        = 10;

    localparam logic [31:0] SEED_MULT    = 32'h6c078965;
    localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc60000;
    localparam logic [31:0] UPPER_MASK   = 32'h80000000;

    typedef struct packed {
        logic accept;
        logic seed_init;
        logic seed_mul;
        logic seed_add;
        logic rd_a;
        logic rd_b;
        logic rd_c;
        logic twist;
        logic temper;
        logic div_step;
        logic add;
        logic out_load;
    } mtp_cmd_t;

    typedef struct packed {
        logic seed_last;
        logic div_last;
        logic need_div;
        logic out_free;
    } mtp_stat_t;

    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction
endpackage

[rtl/mtp_dp.sv]
// Datapath: state memory, seeding multiplier, twist, tempering, serial remainder.
// Depends on mtp_pkg.
module mtp_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  mtp_pkg::mtp_cmd_t cmd,
    output mtp_pkg::mtp_stat_t stat,
    input  logic [31:0]       seed,
    input  logic              in_ranged,
    input  logic [31:0]       in_lo,
    input  logic [31:0]       in_hi,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       out_value
);
    import mtp_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);
    localparam logic [IDX_W-1:0] OFS      = IDX_W'(TWIST_OFFSET);
    localparam logic [IDX_W-1:0] WRAP     = IDX_W'(STATE_WORDS);

    logic [31:0] mem [0:STATE_WORDS-1];
    logic [31:0] rdata_reg;
    logic [IDX_W-1:0] raddr, waddr;
    logic [31:0] wdata;
    logic we;

    logic [IDX_W-1:0] idx_reg, cnt_reg;
    logic [31:0] p_reg, prod_reg, a_reg, b_reg, tw_reg, word_reg;
    logic [31:0] lo_reg, ivl_reg, q_reg, res_reg;
    logic [32:0] rem_reg;
    logic        ranged_reg;
    logic [4:0]  dcnt_reg;
    logic        ovalid_reg;
    logic [31:0] odata_reg;

    logic [IDX_W-1:0] nxt, far, far_sum;
    logic [31:0] y, twisted, seed_word;
    logic [32:0] r2;

    assign nxt     = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
    assign far_sum = idx_reg + OFS;
    assign far     = (far_sum >= WRAP) ? far_sum - WRAP : far_sum;

    assign y       = (a_reg & UPPER_MASK) | (b_reg & ~UPPER_MASK);
    assign twisted = rdata_reg ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : 32'h0);
    assign seed_word = prod_reg + {{(32-IDX_W){1'b0}}, cnt_reg};

    always_comb
    begin
        raddr = idx_reg;
        if (cmd.rd_a)
            raddr = idx_reg;
        else if (cmd.rd_b)
            raddr = nxt;
        else if (cmd.rd_c)
            raddr = far;
        we    = cmd.seed_init | cmd.seed_add | cmd.twist;
        waddr = cmd.twist ? idx_reg : (cmd.seed_init ? '0 : cnt_reg);
        wdata = cmd.twist ? twisted : (cmd.seed_init ? seed : seed_word);
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign r2 = {rem_reg[31:0], q_reg[31]};

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.seed_init)
            p_reg <= seed;
        else if (cmd.seed_add)
            p_reg <= seed_word;
        if (cmd.seed_mul)
            prod_reg <= SEED_MULT * (p_reg ^ (p_reg >> 30));
        if (cmd.rd_b)
            a_reg <= rdata_reg;
        if (cmd.rd_c)
            b_reg <= rdata_reg;
        if (cmd.twist)
            tw_reg <= twisted;
        if (cmd.accept)
        begin
            ranged_reg <= in_ranged;
            lo_reg     <= in_lo;
            ivl_reg    <= in_hi - in_lo + 32'd1;
        end
        if (cmd.temper)
        begin
            word_reg <= temper(tw_reg);
            q_reg    <= temper(tw_reg);
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            q_reg   <= {q_reg[30:0], 1'b0};
            rem_reg <= (r2 >= {1'b0, ivl_reg}) ? r2 - {1'b0, ivl_reg} : r2;
        end
        if (cmd.add)
            res_reg <= stat.need_div ? lo_reg + rem_reg[31:0] : word_reg;
        if (cmd.out_load)
            odata_reg <= res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            cnt_reg    <= '0;
            dcnt_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.seed_init)
            begin
                idx_reg <= '0;
                cnt_reg <= IDX_W'(1);
            end
            else if (cmd.seed_add)
                cnt_reg <= cnt_reg + 1'b1;
            if (cmd.twist)
                idx_reg <= nxt;
            if (cmd.temper)
                dcnt_reg <= '0;
            else if (cmd.div_step)
                dcnt_reg <= dcnt_reg + 1'b1;
            if (cmd.out_load)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    assign stat.seed_last = (cnt_reg == LAST_IDX);
    assign stat.div_last  = (dcnt_reg == 5'd31);
    assign stat.need_div  = ranged_reg && (ivl_reg != 32'd0);
    assign stat.out_free  = !ovalid_reg || out_ready;

    assign out_valid = ovalid_reg;
    assign out_value = odata_reg;
endmodule

[rtl/mtp_ctrl.sv]
// Controller state machine: sequences seeding, twist, tempering and the remainder.
// Depends on mtp_pkg.
module mtp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               in_valid,
    output logic               in_ready,
    input  mtp_pkg::mtp_stat_t stat,
    output mtp_pkg::mtp_cmd_t  cmd
);
    import mtp_pkg::*;

    localparam logic [3:0] S_SINIT = 4'd0;
    localparam logic [3:0] S_SMUL  = 4'd1;
    localparam logic [3:0] S_SADD  = 4'd2;
    localparam logic [3:0] S_IDLE  = 4'd3;
    localparam logic [3:0] S_RA    = 4'd4;
    localparam logic [3:0] S_RB    = 4'd5;
    localparam logic [3:0] S_RC    = 4'd6;
    localparam logic [3:0] S_TW    = 4'd7;
    localparam logic [3:0] S_TEMP  = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_ADD   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0] state_reg, state_next;

    // a seed write takes priority over a waiting transaction
    assign in_ready = (state_reg == S_IDLE) && !cfg_we;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_SINIT:
            begin
                cmd.seed_init = 1'b1;
                state_next    = S_SMUL;
            end
            S_SMUL:
            begin
                cmd.seed_mul = 1'b1;
                state_next   = S_SADD;
            end
            S_SADD:
            begin
                cmd.seed_add = 1'b1;
                state_next   = stat.seed_last ? S_IDLE : S_SMUL;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_RA;
                end
            end
            S_RA:
            begin
                cmd.rd_a   = 1'b1;
                state_next = S_RB;
            end
            S_RB:
            begin
                cmd.rd_b   = 1'b1;
                state_next = S_RC;
            end
            S_RC:
            begin
                cmd.rd_c   = 1'b1;
                state_next = S_TW;
            end
            S_TW:
            begin
                cmd.twist  = 1'b1;
                state_next = S_TEMP;
            end
            S_TEMP:
            begin
                cmd.temper = 1'b1;
                state_next = stat.need_div ? S_DIV : S_ADD;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        // a seed write restarts the fill
        if (cfg_we)
        begin
            cmd        = '0;
            state_next = S_SINIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_SINIT;
        else
            state_reg <= state_next;
    end
endmodule

[rtl/mersenne_twister_prng.sv]
// Top level of the MT19937 generator: seed register, controller and datapath.
// Depends on mtp_pkg, mtp_ctrl, mtp_dp and mersenne_twister_prng_macros.svh.
//
// channel  dir  fields
// s_*      in   tuser: ranged; tdata: low_bound[31:0], high_bound[63:32]
// m_*      out  tdata: value[31:0]
// cfg_*    in   cfg_data: seed_value
//
// One transaction at a time, passing three reads from the state memory's single
// read port and, if ranged below the full span, the 32-step serial remainder.
// After reset or a seed write the 624-word state is filled with s_tready low,
// the first word from the seed, each other by a multiply and an add step. The
// output register lets a new transaction be accepted while a result waits on m_tready.
module mersenne_twister_prng (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // low_bound, high_bound
    input  logic        s_tuser,   // ranged
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // value
);
    import mtp_pkg::*;

    `include "mersenne_twister_prng_macros.svh"

    logic [31:0] seed_reg;
    mtp_cmd_t    cmd;
    mtp_stat_t   stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= '0;
        else if (cfg_we)
            seed_reg <= cfg_data;
    end

    mtp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mtp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .seed      (seed_reg),
        .in_ranged (s_tuser),
        .in_lo     (s_tdata[31:0]),
        .in_hi     (s_tdata[63:32]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (m_tdata)
    );

    `MTP_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `MTP_ASSERT_NEXT(a_seed_blocks, cfg_we, !s_tready)
    `MTP_ASSERT(a_one_cmd, $countones({cmd.seed_mul, cmd.seed_add, cmd.twist, cmd.div_step}) <= 1)
endmodule

[sim/testbench.sv]
// Self-checking testbench for the MT19937 generator (mersenne_twister_prng).
// Predicts every word from its own state copy; depends on mtp_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
    import mtp_pkg::*;

    localparam int N_RANDOM  = 640;
    localparam int CYC_LIMIT = 400000;

    typedef struct {
        logic        ranged;
        logic [31:0] lo;
        logic [31:0] hi;
        logic        known;
        logic [31:0] value;
    } req_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    logic [31:0] mt_words [STATE_WORDS];
    int unsigned mt_pos;
    logic [31:0] words_due [$];
    int          fails = 0;
    int          cycles = 0;
    int          rdy_wait = 0;
    bit          stim_done = 1'b0;
    req_row_t    rows [$];

    mersenne_twister_prng u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void seed_state(input logic [31:0] s);
        logic [31:0] p;
        mt_words[0] = s;
        for (int i = 1; i < STATE_WORDS; i++)
        begin
            p = mt_words[i-1];
            mt_words[i] = SEED_MULT * (p ^ (p >> 30)) + 32'(i);
        end
        mt_pos = STATE_WORDS;
    endfunction

    function automatic logic [31:0] next_word(input logic ranged, input logic [31:0] lo,
                                              input logic [31:0] hi);
        logic [31:0] y, w, span;
        if (mt_pos >= STATE_WORDS)
            mt_pos = 0;
        y = (mt_words[mt_pos] & UPPER_MASK) |
            (mt_words[(mt_pos + 1) % STATE_WORDS] & ~UPPER_MASK);
        mt_words[mt_pos] = mt_words[(mt_pos + TWIST_OFFSET) % STATE_WORDS] ^ (y >> 1) ^
                           (y[0] ? TWIST_MATRIX : 32'h0);
        w = mt_words[mt_pos];
        w = w ^ (w >> 11);
        w = w ^ ((w << 7) & TEMPER_B);
        w = w ^ ((w << 15) & TEMPER_C);
        w = w ^ (w >> 18);
        mt_pos++;
        span = hi - lo + 32'd1;
        if (ranged && span != 32'd0)
            return lo + (w % span);
        return w;
    endfunction

    // result side: random ready stall after each result, compare against oldest prediction
    always @(posedge clk)
    begin
        logic [31:0] want;
        cycles <= cycles + 1;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (words_due.size() == 0)
                begin
                    $display("%0t unexpected result: expected none actual %h", $time, m_tdata);
                    fails++;
                end
                else
                begin
                    want = words_due.pop_front();
                    if (want !== m_tdata)
                    begin
                        $display("%0t value mismatch: expected %h actual %h",
                                 $time, want, m_tdata);
                        fails++;
                    end
                end
                rdy_wait = $urandom_range(0, 9);
            end
            else if (rdy_wait > 0)
                rdy_wait--;
            m_tready <= (rdy_wait == 0);
        end
    end

    always @(posedge clk)
    begin
        if (cycles >= CYC_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_req(input logic ranged, input logic [31:0] lo, input logic [31:0] hi);
        int gap;
        gap = (cycles % 3000 < 400) ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        words_due.push_back(next_word(ranged, lo, hi));
        s_tvalid <= 1'b1;
        s_tuser  <= ranged;
        s_tdata  <= {hi, lo};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (words_due.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] s);
        cfg_we   <= 1'b1;
        cfg_data <= s;
        @(posedge clk);
        cfg_we <= 1'b0;
        seed_state(s);
    endtask

    task automatic run_random(input int n);
        logic [31:0] lo, hi;
        for (int i = 0; i < n; i++)
        begin
            lo = $urandom();
            case ($urandom_range(0, 3))
                0: hi = lo + $urandom_range(0, 20);
                1: hi = $urandom();
                2: hi = lo - 32'd1;
                default: hi = lo + $urandom_range(0, 65535);
            endcase
            send_req($urandom_range(0, 1), lo, hi);
        end
    endtask

    initial
    begin
        seed_state(32'd0);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, full range, inverted and degenerate bounds
        rows.push_back('{1'b0, 32'h0, 32'h0, 1'b0, 32'h0});
        rows.push_back('{1'b1, 32'h0, 32'hffffffff, 1'b0, 32'h0});
        rows.push_back('{1'b1, 32'h5, 32'h5, 1'b1, 32'h5});
        rows.push_back('{1'b1, 32'hffffffff, 32'hffffffff, 1'b1, 32'hffffffff});
        rows.push_back('{1'b1, 32'h0, 32'h0, 1'b1, 32'h0});
        rows.push_back('{1'b1, 32'h0, 32'h1, 1'b0, 32'h0});
        rows.push_back('{1'b1, 32'hfffffff6, 32'h0000000a, 1'b0, 32'h0});
        rows.push_back('{1'b1, 32'h80000000, 32'h7fffffff, 1'b0, 32'h0});
        rows.push_back('{1'b1, 32'h00000010, 32'h00000003, 1'b0, 32'h0});
        rows.push_back('{1'b1, 32'h7fffffff, 32'h80000000, 1'b0, 32'h0});
        rows.push_back('{1'b0, 32'hffffffff, 32'hffffffff, 1'b0, 32'h0});
        rows.push_back('{1'b1, 32'haaaaaaaa, 32'h55555555, 1'b0, 32'h0});
        rows.push_back('{1'b1, 32'h55555555, 32'haaaaaaaa, 1'b0, 32'h0});
        rows.push_back('{1'b1, 32'h1, 32'hffffffff, 1'b0, 32'h0});
        foreach (rows[k])
        begin
            if (rows[k].known)
            begin
                send_req(rows[k].ranged, rows[k].lo, rows[k].hi);
                if (words_due[words_due.size()-1] !== rows[k].value)
                begin
                    $display("%0t predictor row %0d: expected %h actual %h", $time, k,
                             rows[k].value, words_due[words_due.size()-1]);
                    fails++;
                end
            end
            else
                send_req(rows[k].ranged, rows[k].lo, rows[k].hi);
        end
        drain();                     // sender holds until all results are in

        // continue from the reset seed past a full twist of the state
        run_random(N_RANDOM - 28);
        drain();

        // several seeds incl. all-ones; each followed by random traffic
        write_seed(32'd5489);
        run_random(10);
        drain();
        write_seed(32'hffffffff);
        run_random(10);
        drain();
        write_seed($urandom());
        run_random(8);
        drain();

        if (fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

[files.f]
+incdir+rtl
rtl/mtp_pkg.sv
rtl/mtp_dp.sv
rtl/mtp_ctrl.sv
rtl/mersenne_twister_prng.sv
sim/testbench.sv
